### rtl/core/fswp_pkg.sv
// ----------------------------------------------------------------------------
// fswp_pkg
// Shared types, constants and saturation helpers for the search window
// predictor.
// ----------------------------------------------------------------------------
package fswp_pkg;

   localparam int IMAGE_WIDTH  = 640;
   localparam int IMAGE_HEIGHT = 480;

   // Frame limits in Q12.4 pixels.
   localparam logic signed [39:0] X_LIMIT   = 40'(IMAGE_WIDTH * 16);
   localparam logic signed [39:0] Y_LIMIT   = 40'(IMAGE_HEIGHT * 16);
   localparam logic signed [39:0] LOW_LIMIT = 40'sd16;

   // Yaw magnitude above 0.1 in Q8.16 doubles the margin.
   localparam logic signed [23:0] YAW_LIMIT = 24'sd6553;

   // 1.0 in Q.16.
   localparam logic signed [47:0] UNIT_Q16 = 48'sd65536;

   // Reciprocal of five for a 25-bit shift; exact for magnitudes up to 2^23.
   localparam logic [22:0] DIV5_MUL   = 23'd6710887;
   localparam int          DIV5_SHIFT = 25;

   localparam logic [2:0] CSR_INV_FOCAL     = 3'd0;
   localparam logic [2:0] CSR_FOCAL_DT      = 3'd1;
   localparam logic [2:0] CSR_CENTER_U      = 3'd2;
   localparam logic [2:0] CSR_CENTER_V      = 3'd3;
   localparam logic [2:0] CSR_RADIUS        = 3'd4;
   localparam logic [2:0] CSR_YAW_RATE      = 3'd5;
   localparam logic [2:0] CSR_FORWARD_SPEED = 3'd6;

   localparam logic [1:0] KIND_OUT      = 2'd0;
   localparam logic [1:0] KIND_DEPTH    = 2'd1;
   localparam logic [1:0] KIND_ROTATION = 2'd2;

   typedef struct packed {
      logic        [23:0] inv_focal;
      logic        [31:0] focal_dt;
      logic        [15:0] center_u;
      logic        [15:0] center_v;
      logic        [15:0] radius;
      logic signed [23:0] yaw_rate;
      logic signed [23:0] forward_speed;
   } cfg_type;

   typedef struct packed {
      logic [15:0] point_x;
      logic [15:0] point_y;
      logic [15:0] inverse_depth;
      logic        last_point;
   } req_type;

   typedef struct packed {
      logic        [15:0] box_x_min;
      logic        [15:0] box_x_max;
      logic        [15:0] box_y_min;
      logic        [15:0] box_y_max;
      logic signed [15:0] flow_x;
      logic signed [15:0] flow_y;
      logic        [1:0]  window_kind;
      logic               last_result;
   } rsp_type;

   // Normalization stage results handed to the displacement stages.
   typedef struct packed {
      logic        [15:0] point_x;
      logic        [15:0] point_y;
      logic               depth;
      logic               last;
      logic signed [39:0] rot_x;   // rotation term before negation
      logic signed [39:0] rot_y;
      logic signed [38:0] trans_x; // depth translation term
      logic signed [38:0] trans_y;
      logic signed [36:0] slow_x;  // speed-over-five term
      logic signed [36:0] slow_y;
   } norm_type;

   // Pixel displacements handed to the window stage.
   typedef struct packed {
      logic        [15:0] point_x;
      logic        [15:0] point_y;
      logic               depth;
      logic               last;
      logic signed [35:0] disp_a_x;
      logic signed [35:0] disp_a_y;
      logic signed [35:0] disp_b_x;
      logic signed [35:0] disp_b_y;
      logic signed [15:0] rate_x;
      logic signed [15:0] rate_y;
   } disp_type;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
      if (x > 48'sd2147483647) begin
         sat32 = 32'sh7fffffff;
      end else if (x < -48'sd2147483648) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = x[31:0];
      end
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [47:0] x);
      if (x > 48'sd32767) begin
         sat16 = 16'sh7fff;
      end else if (x < -48'sd32768) begin
         sat16 = 16'sh8000;
      end else begin
         sat16 = x[15:0];
      end
   endfunction

endpackage

### rtl/core/flow_search_window_predict.sv
// ----------------------------------------------------------------------------
// flow_search_window_predict
// Predicts the search window of one tracked feature point per beat.
//
// A point beat enters on req_valid/req_ready and carries its pixel position,
// inverse depth (zero when unknown) and an end-of-set flag. One result beat
// leaves on rsp_valid/rsp_ready for every point, in order, with the clipped
// window, the flow term, the window kind and the copied flag.
// The pipeline has six register stages and takes a new point every cycle
// unless a result is held back, a sustained rate of one point per clock.
// The two widest multiply stages (the normalization products and the focal
// scaling) set the stage depth. When the receiver holds rsp_ready low with
// a result waiting, the whole pipeline holds and req_ready falls; nothing
// is dropped or repeated. Camera and motion registers are written through
// csr_we/csr_index/csr_wdata; the user must write them only while no point
// is in flight; the block does not enforce this. Synchronous reset empties
// the pipeline and restores the register defaults.
// ----------------------------------------------------------------------------
module flow_search_window_predict (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fswp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fswp_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import fswp_pkg::*;

   localparam int STAGES = 6;

   cfg_type           cfg_ff, cfg_in;
   logic [STAGES-1:0] valid_ff, valid_in;
   logic              advance;
   norm_type          norm;
   disp_type          disp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_INV_FOCAL:     cfg_in.inv_focal     = csr_wdata[23:0];
            CSR_FOCAL_DT:      cfg_in.focal_dt      = csr_wdata;
            CSR_CENTER_U:      cfg_in.center_u      = csr_wdata[15:0];
            CSR_CENTER_V:      cfg_in.center_v      = csr_wdata[15:0];
            CSR_RADIUS:        cfg_in.radius        = csr_wdata[15:0];
            CSR_YAW_RATE:      cfg_in.yaw_rate      = $signed(csr_wdata[23:0]);
            CSR_FORWARD_SPEED: cfg_in.forward_speed = $signed(csr_wdata[23:0]);
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_focal     <= 24'd16384;
         cfg_ff.focal_dt      <= 32'd65536;
         cfg_ff.center_u      <= 16'd5120;
         cfg_ff.center_v      <= 16'd3840;
         cfg_ff.radius        <= 16'd160;
         cfg_ff.yaw_rate      <= 24'sd0;
         cfg_ff.forward_speed <= 24'sd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The pipeline moves as a whole unless a finished result is held back.
   assign advance   = !valid_ff[STAGES-1] || rsp_ready;
   assign req_ready = advance;
   assign valid_in  = {valid_ff[STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   fswp_norm u_norm (
      .clock   (clock),
      .advance (advance),
      .cfg     (cfg_ff),
      .req     (req_data),
      .norm    (norm)
   );

   fswp_disp u_disp (
      .clock   (clock),
      .advance (advance),
      .cfg     (cfg_ff),
      .norm    (norm),
      .disp    (disp)
   );

   fswp_window u_window (
      .clock   (clock),
      .advance (advance),
      .cfg     (cfg_ff),
      .disp    (disp),
      .rsp     (rsp_data)
   );

   assign rsp_valid = valid_ff[STAGES-1];

endmodule

### rtl/core/fswp_norm.sv
// ----------------------------------------------------------------------------
// fswp_norm
// Three pipeline stages: normalized coordinates, their products and the
// rotation, translation and speed-over-five flow terms.
// ----------------------------------------------------------------------------
module fswp_norm (
   input  logic              clock,
   input  logic              advance,
   input  fswp_pkg::cfg_type cfg,
   input  fswp_pkg::req_type req,
   output fswp_pkg::norm_type norm
);
   import fswp_pkg::*;

   // Stage 1
   req_type            req1_ff;
   logic signed [29:0] u1_ff, u1_in, v1_ff, v1_in;
   logic signed [16:0] dx, dy;
   logic signed [41:0] pu, pv;

   // Stage 2
   logic [15:0]        px2_ff, py2_ff;
   logic               last2_ff, depth2_ff, depth2_in;
   logic signed [29:0] u2_ff, v2_ff;
   logic signed [43:0] uu2_ff, uu2_in, uv2_ff, uv2_in;
   logic signed [30:0] ax2_ff, ax2_in, ay2_ff, ay2_in;
   logic signed [22:0] v5_ff, v5_in;
   logic signed [59:0] puu, puv;
   logic signed [46:0] pax, pay;
   logic [23:0]        speed_mag;
   logic [46:0]        pq;
   logic [21:0]        quot;

   // Stage 3
   norm_type           norm_ff, norm_in;
   logic signed [55:0] prx, pry;
   logic signed [54:0] ptx, pty;
   logic signed [52:0] psx, psy;

   always_comb begin
      dx    = $signed({1'b0, req.point_x}) - $signed({1'b0, cfg.center_u});
      dy    = $signed({1'b0, req.point_y}) - $signed({1'b0, cfg.center_v});
      pu    = dx * $signed({1'b0, cfg.inv_focal});
      pv    = dy * $signed({1'b0, cfg.inv_focal});
      u1_in = pu[41:12];
      v1_in = pv[41:12];
   end

   always_comb begin
      puu    = u1_ff * u1_ff;
      puv    = u1_ff * v1_ff;
      uu2_in = puu[59:16];
      uv2_in = puv[59:16];
      pax    = u1_ff * $signed({1'b0, req1_ff.inverse_depth});
      pay    = v1_ff * $signed({1'b0, req1_ff.inverse_depth});
      ax2_in = pax[46:16];
      ay2_in = pay[46:16];
      // Quotient by five truncates toward zero, so divide the magnitude.
      speed_mag = cfg.forward_speed[23] ? 24'(-cfg.forward_speed)
                                        : 24'(cfg.forward_speed);
      pq    = 47'(speed_mag) * 47'(DIV5_MUL);
      quot  = pq[46:DIV5_SHIFT];
      v5_in = cfg.forward_speed[23] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
      depth2_in = (req1_ff.inverse_depth != 16'd0) && (cfg.forward_speed > 24'sd0);
   end

   always_comb begin
      prx = sat32(48'(uu2_ff) + UNIT_Q16) * cfg.yaw_rate;
      pry = sat32(48'(uv2_ff)) * cfg.yaw_rate;
      ptx = ax2_ff * cfg.forward_speed;
      pty = ay2_ff * cfg.forward_speed;
      psx = v5_ff * u2_ff;
      psy = v5_ff * v2_ff;
      norm_in.point_x = px2_ff;
      norm_in.point_y = py2_ff;
      norm_in.depth   = depth2_ff;
      norm_in.last    = last2_ff;
      norm_in.rot_x   = prx[55:16];
      norm_in.rot_y   = pry[55:16];
      norm_in.trans_x = ptx[54:16];
      norm_in.trans_y = pty[54:16];
      norm_in.slow_x  = psx[52:16];
      norm_in.slow_y  = psy[52:16];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         req1_ff   <= req;
         u1_ff     <= u1_in;
         v1_ff     <= v1_in;
         px2_ff    <= req1_ff.point_x;
         py2_ff    <= req1_ff.point_y;
         last2_ff  <= req1_ff.last_point;
         depth2_ff <= depth2_in;
         u2_ff     <= u1_ff;
         v2_ff     <= v1_ff;
         uu2_ff    <= uu2_in;
         uv2_ff    <= uv2_in;
         ax2_ff    <= ax2_in;
         ay2_ff    <= ay2_in;
         v5_ff     <= v5_in;
         norm_ff   <= norm_in;
      end
   end

   assign norm = norm_ff;

endmodule

### rtl/core/fswp_disp.sv
// ----------------------------------------------------------------------------
// fswp_disp
// Two pipeline stages: sums the flow terms, then scales them to pixel
// displacements by focal length times frame interval.
// ----------------------------------------------------------------------------
module fswp_disp (
   input  logic               clock,
   input  logic               advance,
   input  fswp_pkg::cfg_type  cfg,
   input  fswp_pkg::norm_type norm,
   output fswp_pkg::disp_type disp
);
   import fswp_pkg::*;

   // Stage 4
   logic [15:0]        px4_ff, py4_ff;
   logic               depth4_ff, last4_ff;
   logic signed [31:0] opa_x_ff, opa_x_in, opa_y_ff, opa_y_in;
   logic signed [31:0] opb_x_ff, opb_x_in, opb_y_ff, opb_y_in;
   logic signed [15:0] rate_x_ff, rate_x_in, rate_y_ff, rate_y_in;
   logic signed [40:0] rot_x, rot_y;
   logic signed [41:0] nx, ny, sx, sy;

   // Stage 5
   disp_type           disp_ff, disp_in;
   logic signed [31:0] fdt;
   logic signed [63:0] pax, pay, pbx, pby;

   always_comb begin
      rot_x = -41'(norm.rot_x);
      rot_y = -41'(norm.rot_y);
      nx    = 42'(norm.trans_x) + 42'(rot_x);
      ny    = 42'(norm.trans_y) + 42'(rot_y);
      sx    = 42'(norm.slow_x) + 42'(rot_x);
      sy    = 42'(norm.slow_y) + 42'(rot_y);
      // The depth window moves by the full flow, the rotation window by the
      // rotation term alone on one side of its box.
      opa_x_in  = norm.depth ? sat32(48'(nx)) : sat32(48'(rot_x));
      opa_y_in  = norm.depth ? sat32(48'(ny)) : sat32(48'(rot_y));
      opb_x_in  = sat32(48'(sx));
      opb_y_in  = sat32(48'(sy));
      rate_x_in = sat16(48'($signed(nx[41:12])));
      rate_y_in = sat16(48'($signed(ny[41:12])));
   end

   always_comb begin
      fdt = (cfg.focal_dt > 32'h7fffffff) ? 32'sh7fffffff : $signed(cfg.focal_dt);
      pax = opa_x_ff * fdt;
      pay = opa_y_ff * fdt;
      pbx = opb_x_ff * fdt;
      pby = opb_y_ff * fdt;
      disp_in.point_x  = px4_ff;
      disp_in.point_y  = py4_ff;
      disp_in.depth    = depth4_ff;
      disp_in.last     = last4_ff;
      disp_in.disp_a_x = pax[63:28];
      disp_in.disp_a_y = pay[63:28];
      disp_in.disp_b_x = pbx[63:28];
      disp_in.disp_b_y = pby[63:28];
      disp_in.rate_x   = rate_x_ff;
      disp_in.rate_y   = rate_y_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         px4_ff    <= norm.point_x;
         py4_ff    <= norm.point_y;
         depth4_ff <= norm.depth;
         last4_ff  <= norm.last;
         opa_x_ff  <= opa_x_in;
         opa_y_ff  <= opa_y_in;
         opb_x_ff  <= opb_x_in;
         opb_y_ff  <= opb_y_in;
         rate_x_ff <= rate_x_in;
         rate_y_ff <= rate_y_in;
         disp_ff   <= disp_in;
      end
   end

   assign disp = disp_ff;

endmodule

### rtl/core/fswp_window.sv
// ----------------------------------------------------------------------------
// fswp_window
// Final stage: forms the window, clips it to the frame (or marks the point
// out of frame) and registers the result beat.
// ----------------------------------------------------------------------------
module fswp_window (
   input  logic               clock,
   input  logic               advance,
   input  fswp_pkg::cfg_type  cfg,
   input  fswp_pkg::disp_type disp,
   output fswp_pkg::rsp_type  rsp
);
   import fswp_pkg::*;

   rsp_type            rsp_ff, rsp_in;
   logic signed [39:0] pxe, pye, ax, ay, bx, by, fxr, fyr;
   logic signed [39:0] lo_x, hi_x, lo_y, hi_y, margin;
   logic signed [39:0] xmin, xmax, ymin, ymax;
   logic [17:0]        r;
   logic [18:0]        m;
   logic               in_frame;

   always_comb begin
      pxe = $signed({24'd0, disp.point_x});
      pye = $signed({24'd0, disp.point_y});
      ax  = pxe - 40'(disp.disp_a_x);
      ay  = pye - 40'(disp.disp_a_y);
      fxr = -40'(disp.disp_b_x);
      fyr = -40'(disp.disp_b_y);
      bx  = pxe + fxr;
      by  = pye + fyr;

      r = ((cfg.yaw_rate > YAW_LIMIT) || (cfg.yaw_rate < -YAW_LIMIT))
          ? {1'b0, cfg.radius, 1'b0} : {2'b00, cfg.radius};
      m = disp.depth ? {r, 1'b0} : {1'b0, r};
      margin = $signed({21'd0, m});

      // The depth window is centered on one point, so both bounds coincide.
      if (disp.depth) begin
         lo_x = ax;
         hi_x = ax;
         lo_y = ay;
         hi_y = ay;
      end else begin
         lo_x = (ax < bx) ? ax : bx;
         hi_x = (ax > bx) ? ax : bx;
         lo_y = (ay < by) ? ay : by;
         hi_y = (ay > by) ? ay : by;
      end

      in_frame = !((lo_x < LOW_LIMIT) || (lo_y < LOW_LIMIT) ||
                   (hi_x > X_LIMIT) || (hi_y > Y_LIMIT));

      xmin = ((lo_x - margin) > LOW_LIMIT) ? (lo_x - margin) : LOW_LIMIT;
      xmax = ((hi_x + margin) < X_LIMIT) ? (hi_x + margin) : X_LIMIT;
      ymin = ((lo_y - margin) > LOW_LIMIT) ? (lo_y - margin) : LOW_LIMIT;
      ymax = ((hi_y + margin) < Y_LIMIT) ? (hi_y + margin) : Y_LIMIT;

      rsp_in.flow_x      = disp.depth ? disp.rate_x : sat16(48'(fxr));
      rsp_in.flow_y      = disp.depth ? disp.rate_y : sat16(48'(fyr));
      rsp_in.last_result = disp.last;
      if (in_frame) begin
         rsp_in.box_x_min   = xmin[15:0];
         rsp_in.box_x_max   = xmax[15:0];
         rsp_in.box_y_min   = ymin[15:0];
         rsp_in.box_y_max   = ymax[15:0];
         rsp_in.window_kind = disp.depth ? KIND_DEPTH : KIND_ROTATION;
      end else begin
         rsp_in.box_x_min   = 16'd0;
         rsp_in.box_x_max   = 16'd0;
         rsp_in.box_y_min   = 16'd0;
         rsp_in.box_y_max   = 16'd0;
         rsp_in.window_kind = KIND_OUT;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule
